/* sv/bct_pkg.sv */
// Shared types, constants, slot arithmetic and control store of the binomial table.
`default_nettype none

package bct_pkg;

    localparam int MAX_N_DEF       = 64;
    localparam int COEFF_WIDTH_DEF = 64;
    localparam int COEFF_BITS      = 64;
    localparam int ROW_BITS        = 7;
    localparam int COL_BITS        = 6;
    localparam int SLOT_BITS       = 14;
    localparam int MIN_STORED_ROW  = 4;
    localparam int FIRST_COL       = 2;
    localparam int SEED_ROW        = 5;
    localparam int SEED_LO_VALUE   = 6;
    localparam int SEED_HI_VALUE   = 10;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_FILL  = 1'b1;

    // Steps of the control program
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_CMD,
        ST_Q_RANGE,
        ST_Q_FOLD,
        ST_FILL_CHK,
        ST_ROW_INIT,
        ST_COL_READ,
        ST_COL_WRITE,
        ST_ROW_END,
        ST_AFTER_FILL,
        ST_READ,
        ST_TAKE,
        ST_EMIT
    } step_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIRECT,
        OP_FOLD,
        OP_SET_TARGET,
        OP_ROW_INIT,
        OP_COL_READ,
        OP_COL_WRITE,
        OP_ROW_DONE,
        OP_QUERY_READ,
        OP_TAKE,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_IN_FIRE,
        C_IS_FILL,
        C_DIRECT,
        C_FILLED,
        C_NO_FILL,
        C_COL_MORE,
        C_ROW_MORE,
        C_OUT_BUSY
    } cond_t;

    // One control word: datapath operation, branch condition, taken and fall targets
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jt;
        step_t jf;
    } ctrl_t;

    function automatic int store_depth(int max_n);
        int m;
        int q;
        int r;
        m = max_n + 1;
        q = m / 2;
        r = m % 2;
        return q * q + r * q - 3 * q - r + 2;
    endfunction

    // Dense slot of row n, column k in the left half of rows four and up
    function automatic logic [SLOT_BITS-1:0] slot_of(logic [ROW_BITS-1:0] n,
                                                     logic [ROW_BITS-1:0] k);
        logic [SLOT_BITS-1:0] q;
        logic [SLOT_BITS-1:0] r;
        q = SLOT_BITS'(n >> 1);
        r = SLOT_BITS'(n[0]);
        return q * q + r * q + SLOT_BITS'(k) - (q + q + q) - r;
    endfunction

    function automatic ctrl_t microcode(step_t s);
        ctrl_t w;
        unique case (s)
            ST_IDLE:       w = '{OP_LOAD,       C_IN_FIRE,  ST_CHK_CMD,  ST_IDLE};
            ST_CHK_CMD:    w = '{OP_NOP,        C_IS_FILL,  ST_FILL_CHK, ST_Q_RANGE};
            ST_Q_RANGE:    w = '{OP_DIRECT,     C_DIRECT,   ST_EMIT,     ST_Q_FOLD};
            ST_Q_FOLD:     w = '{OP_FOLD,       C_FILLED,   ST_READ,     ST_ROW_INIT};
            ST_FILL_CHK:   w = '{OP_SET_TARGET, C_NO_FILL,  ST_IDLE,     ST_ROW_INIT};
            ST_ROW_INIT:   w = '{OP_ROW_INIT,   C_ALWAYS,   ST_COL_READ, ST_COL_READ};
            ST_COL_READ:   w = '{OP_COL_READ,   C_ALWAYS,   ST_COL_WRITE, ST_COL_WRITE};
            ST_COL_WRITE:  w = '{OP_COL_WRITE,  C_COL_MORE, ST_COL_READ, ST_ROW_END};
            ST_ROW_END:    w = '{OP_ROW_DONE,   C_ROW_MORE, ST_COL_READ, ST_AFTER_FILL};
            ST_AFTER_FILL: w = '{OP_NOP,        C_IS_FILL,  ST_IDLE,     ST_READ};
            ST_READ:       w = '{OP_QUERY_READ, C_ALWAYS,   ST_TAKE,     ST_TAKE};
            ST_TAKE:       w = '{OP_TAKE,       C_ALWAYS,   ST_EMIT,     ST_EMIT};
            ST_EMIT:       w = '{OP_EMIT,       C_OUT_BUSY, ST_EMIT,     ST_IDLE};
            default:       w = '{OP_NOP,        C_ALWAYS,   ST_IDLE,     ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* sv/bct_if.sv */
// Request and response channel interfaces of the binomial table.
`default_nettype none

interface bct_req_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [bct_pkg::ROW_BITS-1:0]  row_n;
    logic [bct_pkg::ROW_BITS-1:0]  column_k;

    modport source (output valid, output command, output row_n, output column_k,
                    input ready);
    modport sink   (input valid, input command, input row_n, input column_k,
                    output ready);
endinterface

interface bct_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bct_pkg::COEFF_BITS-1:0]  coefficient;
    logic                            out_of_range;

    modport source (output valid, output coefficient, output out_of_range,
                    input ready);
    modport sink   (input valid, input coefficient, input out_of_range,
                    output ready);
endinterface

`default_nettype wire

/* sv/binomial_coefficient_table_core.sv */
// Top level: binomial coefficient table driven by a microcoded sequencer.
//
// req carries items {command, row_n, column_k}; rsp carries {coefficient, out_of_range}.
// An item is taken when valid and ready are high at a rising edge. req.ready is high
// only while the sequencer sits in its idle step; one item is worked on at a time.
// A query gives one rsp item; a prefill (command 1) gives none.
// Steps per item, counted from acceptance back to ready:
//   query answered without the store (k of 0, 1, n-1, n or above n, or n above MAX_N):
//   command check, range check, emit; a query on a filled row adds a fold and two
//   address/read steps on the store RAM port; a prefill with nothing to build
//   ends after its fill check. Building rows takes a read and a write step per stored
//   column, a step per row, and a row setup and a return step per fill run.
// Rows 4 and 5 are seeded by constant, so the store needs no clearing pass; reset
// marks row 5 as the highest filled row and empties the output register.
// A result is held in the output register until rsp.ready; meanwhile the sequencer
// may take the next item, and waits in its emit step only if a second result is due
// before the first one is taken.
`default_nettype none

module binomial_coefficient_table_core #(
    parameter int MAX_N       = bct_pkg::MAX_N_DEF,
    parameter int COEFF_WIDTH = bct_pkg::COEFF_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bct_req_if.sink    req,
    bct_rsp_if.source  rsp
);

    localparam int STORE_DEPTH = bct_pkg::store_depth(MAX_N);
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int RB          = bct_pkg::ROW_BITS;
    localparam int CB          = bct_pkg::COL_BITS;

    localparam logic [RB-1:0] MAX_ROW   = RB'(MAX_N);
    localparam logic [RB-1:0] MIN_ROW   = RB'(bct_pkg::MIN_STORED_ROW);
    localparam logic [RB-1:0] SEED_ROW  = RB'(bct_pkg::SEED_ROW);
    localparam logic [CB-1:0] FIRST_COL = CB'(bct_pkg::FIRST_COL);

    bct_pkg::step_t step_reg, step_next;
    bct_pkg::ctrl_t ctrl;

    logic                   cmd_reg,     cmd_next;
    logic [RB-1:0]          n_reg,       n_next;
    logic [RB-1:0]          k_reg,       k_next;
    logic [CB-1:0]          kq_reg,      kq_next;
    logic [RB-1:0]          target_reg,  target_next;
    logic [RB-1:0]          highest_reg, highest_next;
    logic [RB-1:0]          row_reg,     row_next;
    logic [CB-1:0]          col_reg,     col_next;
    logic [COEFF_WIDTH-1:0] prev_reg,    prev_next;
    logic [COEFF_WIDTH-1:0] result_reg,  result_next;
    logic                   oor_reg,     oor_next;
    logic                   seed_lo_reg, seed_lo_next;
    logic                   seed_hi_reg, seed_hi_next;
    logic                   out_valid_reg, out_valid_next;
    logic [bct_pkg::COEFF_BITS-1:0] out_coeff_reg, out_coeff_next;
    logic                   out_oor_reg, out_oor_next;

    logic                   in_fire;
    logic                   n_over;
    logic                   direct;
    logic [COEFF_WIDTH-1:0] direct_value;
    logic [RB-1:0]          n_minus_k;
    logic [RB-1:0]          sat_target;
    logic                   filled;
    logic                   no_fill;
    logic                   col_more;
    logic                   row_more;
    logic                   right_valid;
    logic                   out_busy;
    logic                   cond_true;
    logic [RB-1:0]          prev_row;

    logic                   rd_en;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic [COEFF_WIDTH-1:0] rd_data;
    logic [COEFF_WIDTH-1:0] rd_val;
    logic                   wr_en;
    logic [ADDR_BITS-1:0]   wr_addr;
    logic [COEFF_WIDTH-1:0] right;
    logic [COEFF_WIDTH-1:0] sum;
    logic                   out_load;

    // ---------------------------------------------------------------- conditions
    assign req.ready = (step_reg == bct_pkg::ST_IDLE);
    assign in_fire   = req.valid && req.ready;

    assign n_over     = n_reg > MAX_ROW;
    assign n_minus_k  = n_reg - k_reg;
    assign direct     = n_over || (k_reg > n_reg) || (k_reg == '0) || (k_reg == n_reg)
                        || (k_reg == RB'(1)) || (k_reg == n_reg - RB'(1));
    assign filled     = n_reg <= highest_reg;
    assign sat_target = n_over ? MAX_ROW : n_reg;
    assign no_fill    = (n_reg < MIN_ROW) || (sat_target <= highest_reg);
    assign col_more   = RB'(col_reg) < (row_reg >> 1);
    assign row_more   = row_reg < target_reg;
    assign prev_row   = row_reg - RB'(1);
    assign right_valid = RB'(col_reg) <= (prev_row >> 1);
    assign out_busy   = out_valid_reg && !rsp.ready;

    always_comb
    begin
        priority if (n_over || (k_reg > n_reg))
        begin
            direct_value = '0;
        end
        else if ((k_reg == '0) || (k_reg == n_reg))
        begin
            direct_value = COEFF_WIDTH'(1);
        end
        else
        begin
            direct_value = COEFF_WIDTH'(n_reg);
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        unique case (ctrl.cond)
            bct_pkg::C_ALWAYS:   cond_true = 1'b1;
            bct_pkg::C_IN_FIRE:  cond_true = in_fire;
            bct_pkg::C_IS_FILL:  cond_true = (cmd_reg == bct_pkg::CMD_FILL);
            bct_pkg::C_DIRECT:   cond_true = direct;
            bct_pkg::C_FILLED:   cond_true = filled;
            bct_pkg::C_NO_FILL:  cond_true = no_fill;
            bct_pkg::C_COL_MORE: cond_true = col_more;
            bct_pkg::C_ROW_MORE: cond_true = row_more;
            bct_pkg::C_OUT_BUSY: cond_true = out_busy;
            default:             cond_true = 1'b0;
        endcase
        step_next = cond_true ? ctrl.jt : ctrl.jf;
    end

    always_comb
    begin
        ctrl     = bct_pkg::microcode(step_reg);
        rd_en    = (ctrl.op == bct_pkg::OP_COL_READ) || (ctrl.op == bct_pkg::OP_QUERY_READ);
        wr_en    = (ctrl.op == bct_pkg::OP_COL_WRITE);
        out_load = (ctrl.op == bct_pkg::OP_EMIT) && !out_busy;
    end

    // ---------------------------------------------------------------- store
    always_comb
    begin
        if (ctrl.op == bct_pkg::OP_QUERY_READ)
        begin
            rd_addr = ADDR_BITS'(bct_pkg::slot_of(n_reg, RB'(kq_reg)));
        end
        else
        begin
            rd_addr = ADDR_BITS'(bct_pkg::slot_of(prev_row, RB'(col_reg)));
        end
        wr_addr = ADDR_BITS'(bct_pkg::slot_of(row_reg, RB'(col_reg)));
    end

    bct_ram #(
        .WIDTH (COEFF_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (sum),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Rows four and five live in constants, never in the RAM
    always_comb
    begin
        priority if (seed_lo_reg)
        begin
            rd_val = COEFF_WIDTH'(bct_pkg::SEED_LO_VALUE);
        end
        else if (seed_hi_reg)
        begin
            rd_val = COEFF_WIDTH'(bct_pkg::SEED_HI_VALUE);
        end
        else
        begin
            rd_val = rd_data;
        end
    end

    // Past the middle of the row above, its mirror equals the left neighbour
    assign right = right_valid ? rd_val : prev_reg;
    assign sum   = prev_reg + right;

    // ---------------------------------------------------------------- datapath
    always_comb
    begin
        cmd_next     = cmd_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        kq_next      = kq_reg;
        target_next  = target_reg;
        highest_next = highest_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        prev_next    = prev_reg;
        result_next  = result_reg;
        oor_next     = oor_reg;
        seed_lo_next = seed_lo_reg;
        seed_hi_next = seed_hi_reg;

        if (rd_en)
        begin
            seed_lo_next = (rd_addr == ADDR_BITS'(0));
            seed_hi_next = (rd_addr == ADDR_BITS'(1));
        end

        unique case (ctrl.op)
            bct_pkg::OP_LOAD:
            begin
                if (in_fire)
                begin
                    cmd_next = req.command;
                    n_next   = req.row_n;
                    k_next   = req.column_k;
                end
            end
            bct_pkg::OP_DIRECT:
            begin
                result_next = direct_value;
                oor_next    = n_over;
            end
            bct_pkg::OP_FOLD:
            begin
                kq_next     = (n_minus_k < k_reg) ? n_minus_k[CB-1:0] : k_reg[CB-1:0];
                target_next = n_reg;
            end
            bct_pkg::OP_SET_TARGET:
            begin
                target_next = sat_target;
            end
            bct_pkg::OP_ROW_INIT:
            begin
                row_next  = highest_reg + RB'(1);
                col_next  = FIRST_COL;
                prev_next = COEFF_WIDTH'(highest_reg);
            end
            bct_pkg::OP_COL_WRITE:
            begin
                prev_next = right;
                col_next  = col_reg + CB'(1);
            end
            bct_pkg::OP_ROW_DONE:
            begin
                highest_next = row_reg;
                row_next     = row_reg + RB'(1);
                col_next     = FIRST_COL;
                prev_next    = COEFF_WIDTH'(row_reg);
            end
            bct_pkg::OP_TAKE:
            begin
                result_next = rd_val;
            end
            bct_pkg::OP_NOP, bct_pkg::OP_COL_READ, bct_pkg::OP_QUERY_READ,
            bct_pkg::OP_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------- output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_coeff_next = out_coeff_reg;
        out_oor_next   = out_oor_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_coeff_next = bct_pkg::COEFF_BITS'(result_reg);
            out_oor_next   = oor_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.coefficient  = out_coeff_reg;
    assign rsp.out_of_range = out_oor_reg;

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= bct_pkg::ST_IDLE;
            highest_reg   <= SEED_ROW;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            highest_reg   <= highest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        n_reg         <= n_next;
        k_reg         <= k_next;
        kq_reg        <= kq_next;
        target_reg    <= target_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        prev_reg      <= prev_next;
        result_reg    <= result_next;
        oor_reg       <= oor_next;
        seed_lo_reg   <= seed_lo_next;
        seed_hi_reg   <= seed_hi_next;
        out_coeff_reg <= out_coeff_next;
        out_oor_reg   <= out_oor_next;
    end

`ifndef SYNTHESIS
    a_highest_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> highest_reg >= $past(highest_reg))
        else $error("highest filled row went backwards");

    a_highest_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        highest_reg <= MAX_ROW)
        else $error("highest filled row beyond MAX_N");

    a_no_seed_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr != ADDR_BITS'(0)) && (wr_addr != ADDR_BITS'(1)))
        else $error("store write hit a seeded slot");

    a_write_in_left_half: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (col_reg >= FIRST_COL) && (RB'(col_reg) <= (row_reg >> 1))
                  && (row_reg == highest_reg + RB'(1)))
        else $error("store write outside the row being built");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || rsp.ready))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

/* sv/bct_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bct_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 961
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
